/* sv/qn_pkg.sv */
// Shared definitions for the quaternion normalizer.
// No dependencies.
`default_nettype none
package qn_pkg;

	localparam int NUM_COMP = 4;
	localparam int OUT_BITS = 16;

	typedef enum logic {
		STATUS_OK  = 1'b0,
		STATUS_LOW = 1'b1
	} status_t;

endpackage
`default_nettype wire

/* sv/quaternion_normalizer.sv */
// Quaternion normalizer top level: squares, sum, root, four dividers, saturation.
// Depends on qn_pkg, qn_isqrt and qn_div.
//
// Channel  Direction  Signals                        Content
// s_       in         s_tvalid s_tready s_tdata      comp_x, comp_y, comp_z, comp_w
// m_       out        m_tvalid m_tready m_tdata m_tuser  unit_x..unit_w, status
// cfg_     in         cfg_valid cfg_ready cfg_data   min_norm
//
// One transaction enters per cycle while the pipeline advances; the square root
// resolves one root bit and each divider one quotient bit per stage.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset clears the valid bits and sets min_norm to one.
`default_nettype none
module quaternion_normalizer
	import qn_pkg::*;
#(
	parameter int IN_BITS       = 32,
	parameter int OUT_FRAC_BITS = 14
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// comp_x, comp_y, comp_z, comp_w from the lowest bit up, zero padded.
	input  wire logic [((4*IN_BITS+7)/8)*8-1:0]        s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// unit_x, unit_y, unit_z, unit_w from the lowest bit up.
	output logic      [63:0]                           m_tdata,
	// status.
	output logic      [0:0]                            m_tuser,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [31:0]                           cfg_data
);

	localparam int NC  = NUM_COMP;
	localparam int MW  = IN_BITS;
	localparam int SQW = 2 * IN_BITS;
	localparam int SW  = 2 * IN_BITS + 2;
	localparam int NW  = IN_BITS + 1;
	localparam int QW  = OUT_FRAC_BITS + 1;
	localparam int LS  = NW;
	localparam int LD  = QW;

	logic en;
	logic [31:0] min_norm_q;

	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_norm_q <= 32'd1;
		end else if (cfg_valid) begin
			min_norm_q <= cfg_data;
		end
	end

	logic [NC*MW-1:0] mag_in;
	logic [NC-1:0]    sign_in;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			sign_in[c]            = s_tdata[c*IN_BITS + IN_BITS - 1];
			mag_in[c*MW +: MW]    = sign_in[c] ? MW'(~s_tdata[c*IN_BITS +: IN_BITS] + 1'b1)
			                                   : s_tdata[c*IN_BITS +: IN_BITS];
		end
	end

	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [NC*MW-1:0] mag_s1, mag_s2, mag_s3, mag_s4, mag_s5;
	logic [NC-1:0]    sign_s1, sign_s2, sign_s3, sign_s4, sign_s5;
	logic [SQW-1:0]   sq_s2 [NC];
	logic [SQW:0]     sum_ab_s3, sum_cd_s3;
	logic [SW-1:0]    sum_s4;
	logic [NW-1:0]    root;
	logic [NW-1:0]    norm_s5;
	logic             reject_s5;

	logic             vld_sq  [0:LS];
	logic [NC*MW-1:0] mag_sq  [0:LS];
	logic [NC-1:0]    sign_sq [0:LS];

	logic             vld_dv  [0:LD];
	logic             rej_dv  [0:LD];
	logic [NC-1:0]    sign_dv [0:LD];
	logic [QW-1:0]    quo     [NC];

	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic [0:0]  m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			vld_s1     <= s_tvalid;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			vld_s5     <= vld_sq[LS];
			m_tvalid_q <= vld_dv[LD];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_in;
			sign_s1 <= sign_in;
			for (int c = 0; c < NC; c++) begin
				sq_s2[c] <= SQW'(mag_s1[c*MW +: MW]) * SQW'(mag_s1[c*MW +: MW]);
			end
			mag_s2    <= mag_s1;
			sign_s2   <= sign_s1;
			sum_ab_s3 <= (SQW+1)'(sq_s2[0]) + (SQW+1)'(sq_s2[1]);
			sum_cd_s3 <= (SQW+1)'(sq_s2[2]) + (SQW+1)'(sq_s2[3]);
			mag_s3    <= mag_s2;
			sign_s3   <= sign_s2;
			sum_s4    <= SW'(sum_ab_s3) + SW'(sum_cd_s3);
			mag_s4    <= mag_s3;
			sign_s4   <= sign_s3;
			norm_s5   <= root;
			reject_s5 <= (root == '0) || (33'(root) < 33'(min_norm_q));
			mag_s5    <= mag_sq[LS];
			sign_s5   <= sign_sq[LS];
		end
	end

	qn_isqrt #(
		.IN_BITS(IN_BITS)
	) u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s4),
		.root (root)
	);

	assign vld_sq[0]  = vld_s4;
	assign mag_sq[0]  = mag_s4;
	assign sign_sq[0] = sign_s4;

	for (genvar i = 1; i <= LS; i++) begin : g_sq_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq[i] <= 1'b0;
			end else if (en) begin
				vld_sq[i] <= vld_sq[i-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				mag_sq[i]  <= mag_sq[i-1];
				sign_sq[i] <= sign_sq[i-1];
			end
		end
	end

	for (genvar c = 0; c < NC; c++) begin : g_lane
		qn_div #(
			.IN_BITS       (IN_BITS),
			.OUT_FRAC_BITS (OUT_FRAC_BITS)
		) u_div (
			.clk  (clk),
			.en   (en),
			.mag  (mag_s5[c*MW +: MW]),
			.norm (norm_s5),
			.quo  (quo[c])
		);
	end

	assign vld_dv[0]  = vld_s5;
	assign rej_dv[0]  = reject_s5;
	assign sign_dv[0] = sign_s5;

	for (genvar i = 1; i <= LD; i++) begin : g_dv_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv[i] <= 1'b0;
			end else if (en) begin
				vld_dv[i] <= vld_dv[i-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rej_dv[i]  <= rej_dv[i-1];
				sign_dv[i] <= sign_dv[i-1];
			end
		end
	end

	logic [63:0] unit_next;

	always_comb begin
		logic [31:0] q32;
		logic [31:0] lim;
		for (int c = 0; c < NC; c++) begin
			q32 = 32'(quo[c]);
			lim = 32'd0;
			if (rej_dv[LD]) begin
				unit_next[c*OUT_BITS +: OUT_BITS] = '0;
			end else if (sign_dv[LD][c]) begin
				lim = (q32 > 32'd32768) ? 32'd32768 : q32;
				unit_next[c*OUT_BITS +: OUT_BITS] = OUT_BITS'(32'd0 - lim);
			end else begin
				lim = (q32 > 32'd32767) ? 32'd32767 : q32;
				unit_next[c*OUT_BITS +: OUT_BITS] = OUT_BITS'(lim);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= unit_next;
			m_tuser_q <= rej_dv[LD] ? STATUS_LOW : STATUS_OK;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] == STATUS_LOW) |-> (m_tdata == '0))
		else $error("rejected transaction carries nonzero components");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stage occupancy");

	a_norm_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && !reject_s5) |-> (norm_s5 != '0))
		else $error("accepted transaction with zero norm");
`endif

endmodule
`default_nettype wire

/* sv/qn_isqrt.sv */
// Pipelined integer square root (floor), one root bit per register stage.
// Standalone; used by quaternion_normalizer.
`default_nettype none
module qn_isqrt #(
	parameter int IN_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [2*IN_BITS+1:0] rad,
	output logic      [IN_BITS:0]     root
);

	localparam int SW = 2 * IN_BITS + 2;
	localparam int NW = IN_BITS + 1;

	logic [SW-1:0] rem_s  [0:NW];
	logic [NW-1:0] root_s [0:NW];

	assign rem_s[0]  = rad;
	assign root_s[0] = '0;

	for (genvar j = 0; j < NW; j++) begin : g_stage
		localparam int K = NW - 1 - j;
		logic [SW-1:0] trial;
		logic          take;

		always_comb begin
			trial = (SW'(root_s[j]) << (K + 1)) | (SW'(1) << (2 * K));
			take  = rem_s[j] >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= take ? rem_s[j] - trial : rem_s[j];
				root_s[j+1] <= take ? (root_s[j] | (NW'(1) << K)) : root_s[j];
			end
		end
	end

	assign root = root_s[NW];

endmodule
`default_nettype wire

/* sv/qn_div.sv */
// Pipelined restoring divider for one component, one quotient bit per stage.
// Computes (mag << OUT_FRAC_BITS) / norm for mag not above norm.
`default_nettype none
module qn_div #(
	parameter int IN_BITS       = 32,
	parameter int OUT_FRAC_BITS = 14
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [IN_BITS-1:0]     mag,
	input  wire logic [IN_BITS:0]       norm,
	output logic      [OUT_FRAC_BITS:0] quo
);

	localparam int NW = IN_BITS + 1;
	localparam int RW = NW + 1;
	localparam int QW = OUT_FRAC_BITS + 1;

	logic [RW-1:0] rem_s [0:QW];
	logic [NW-1:0] nrm_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];

	assign rem_s[0] = RW'(mag);
	assign nrm_s[0] = norm;
	assign quo_s[0] = '0;

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [RW-1:0] part;
		logic          take;

		always_comb begin
			if (j == 0) begin
				part = rem_s[j];
			end else begin
				part = {rem_s[j][RW-2:0], 1'b0};
			end
			take = part >= RW'(nrm_s[j]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= take ? part - RW'(nrm_s[j]) : part;
				nrm_s[j+1] <= nrm_s[j];
				quo_s[j+1] <= {quo_s[j][QW-2:0], take};
			end
		end
	end

	assign quo = quo_s[QW];

endmodule
`default_nettype wire
